// File: sv/gcb_pkg.sv
`timescale 1ns / 1ps

package gcb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CORDIC_ITERS_DEF = 20;

  localparam int ANG_W = 44;
  localparam int TRIG_W = 32;
  localparam int VEC_W = 36;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [VEC_W-1:0] vec_t;

  localparam ang_t TURN = 44'sd1546188226560;
  localparam ang_t HALF = 44'sd773094113280;
  localparam ang_t QUARTER = 44'sd386547056640;
  localparam trig_t KINV = 32'sd652032874;

  localparam logic [24:0] FULL_TURN_OUT = 25'd23592960;

  localparam logic signed [23:0] TLAT_RESET = 24'sd1403999;
  localparam logic signed [24:0] TLON_RESET = 25'sd2609862;

  localparam logic REG_TLAT = 1'b0;
  localparam logic REG_TLON = 1'b1;

  localparam int LANES = 3;
  localparam int LANE_LAT = 0;
  localparam int LANE_TLAT = 1;
  localparam int LANE_DLON = 2;

  // atan(2^-i) in degrees with 32 fraction bits, evaluated at elaboration.
  function automatic ang_t atan_entry(input int i);
    longint unsigned s;
    longint unsigned q;
    longint unsigned rem;
    longint unsigned num;
    longint unsigned a;
    longint unsigned b;
    longint unsigned d;
    int n;
    int k;
    int e;
    s = 64'd0;
    if (i == 0) begin
      return ang_t'(64'd193273528320);
    end
    for (n = 0; n < 31; n++) begin
      e = i * (2 * n + 1);
      if (e <= 60) begin
        d = 64'(2 * n + 1);
        num = 64'd1 << (60 - e);
        q = 64'd0;
        rem = 64'd0;
        for (k = 60; k >= 0; k--) begin
          rem = (rem << 1) | ((num >> k) & 64'd1);
          q = q << 1;
          if (rem >= d) begin
            rem = rem - d;
            q = q | 64'd1;
          end
        end
        if ((n & 1) != 0) begin
          s = s - q;
        end else begin
          s = s + q;
        end
      end
    end
    a = s >> 30;
    b = s & ((64'd1 << 30) - 64'd1);
    return ang_t'(((a * 64'd15380218700) >> 26) + ((b * 64'd15380218700) >> 56));
  endfunction

endpackage

// File: sv/gcb_sincos.sv
`timescale 1ns / 1ps

module gcb_sincos
  import gcb_pkg::*;
#(
  parameter int ITERS = CORDIC_ITERS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  ce,
  input  logic  in_valid,
  input  ang_t  ang [LANES],
  output logic  out_valid,
  output trig_t sn [LANES],
  output trig_t cs [LANES]
);

  logic [ITERS:0] vs;
  trig_t xs [ITERS+1][LANES];
  trig_t ys [ITERS+1][LANES];
  ang_t zs [ITERS+1][LANES];
  logic [LANES-1:0] ng [ITERS+1];

  ang_t red [LANES];
  logic [LANES-1:0] fold;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      red[l] = ang[l];
      fold[l] = 1'b0;
      if (red[l] >= HALF) begin
        red[l] = red[l] - TURN;
      end else if (red[l] < -HALF) begin
        red[l] = red[l] + TURN;
      end
      if (red[l] > QUARTER) begin
        red[l] = HALF - red[l];
        fold[l] = 1'b1;
      end else if (red[l] < -QUARTER) begin
        red[l] = -HALF - red[l];
        fold[l] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (ce) begin
      vs[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int l = 0; l < LANES; l++) begin
        xs[0][l] <= KINV;
        ys[0][l] <= '0;
        zs[0][l] <= red[l];
      end
      ng[0] <= fold;
    end
  end

  for (genvar g = 0; g < ITERS; g++) begin : g_iter
    localparam ang_t ATAN_G = atan_entry(g);

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[g+1] <= 1'b0;
      end else if (ce) begin
        vs[g+1] <= vs[g];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        for (int l = 0; l < LANES; l++) begin
          if (zs[g][l] >= 0) begin
            xs[g+1][l] <= xs[g][l] - (ys[g][l] >>> g);
            ys[g+1][l] <= ys[g][l] + (xs[g][l] >>> g);
            zs[g+1][l] <= zs[g][l] - ATAN_G;
          end else begin
            xs[g+1][l] <= xs[g][l] + (ys[g][l] >>> g);
            ys[g+1][l] <= ys[g][l] - (xs[g][l] >>> g);
            zs[g+1][l] <= zs[g][l] + ATAN_G;
          end
        end
        ng[g+1] <= ng[g];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sn[l] = ys[ITERS][l];
      cs[l] = ng[ITERS][l] ? -xs[ITERS][l] : xs[ITERS][l];
    end
  end

  assign out_valid = vs[ITERS];

endmodule

// File: sv/gcb_atan2.sv
`timescale 1ns / 1ps

module gcb_atan2
  import gcb_pkg::*;
#(
  parameter int ITERS = CORDIC_ITERS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic ce,
  input  logic in_valid,
  input  vec_t east,
  input  vec_t north,
  input  logic in_flag,
  output logic out_valid,
  output ang_t angle,
  output logic out_flag
);

  logic [ITERS:0] vs;
  logic [ITERS:0] fl;
  vec_t us [ITERS+1];
  vec_t ws [ITERS+1];
  ang_t zs [ITERS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (ce) begin
      vs[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      fl[0] <= in_flag;
      if (north < 0) begin
        us[0] <= -north;
        ws[0] <= -east;
        zs[0] <= HALF;
      end else begin
        us[0] <= north;
        ws[0] <= east;
        zs[0] <= '0;
      end
    end
  end

  for (genvar g = 0; g < ITERS; g++) begin : g_iter
    localparam ang_t ATAN_G = atan_entry(g);

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[g+1] <= 1'b0;
      end else if (ce) begin
        vs[g+1] <= vs[g];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        fl[g+1] <= fl[g];
        if (ws[g] >= 0) begin
          us[g+1] <= us[g] + (ws[g] >>> g);
          ws[g+1] <= ws[g] - (us[g] >>> g);
          zs[g+1] <= zs[g] + ATAN_G;
        end else begin
          us[g+1] <= us[g] - (ws[g] >>> g);
          ws[g+1] <= ws[g] + (us[g] >>> g);
          zs[g+1] <= zs[g] - ATAN_G;
        end
      end
    end
  end

  assign out_valid = vs[ITERS];
  assign angle = zs[ITERS];
  assign out_flag = fl[ITERS];

endmodule

// File: sv/great_circle_bearing_top.sv
`timescale 1ns / 1ps

// Initial great-circle bearing from an observer position toward a target point.
// The slave stream carries one observer position per item; the master stream
// returns one bearing per item, in 1/65536 degree clockwise from north, with
// tuser high when the direction is undefined (observer at the target or its
// antipode), in which case the bearing is zero.
// The target is set through the write port: index 0 is the latitude, index 1
// the longitude, both in 1/65536 degree. Write it only while no item is in flight.
// The data passes through two CORDIC pipelines of one iteration per stage: the
// sine/cosine rotation, run for three angles side by side, and the atan2 vectoring.
// One item is accepted per cycle. The whole pipeline advances together; when
// the receiver stalls with a result waiting, every stage holds and s_tready
// drops, so nothing is lost or repeated.
// Reset clears all valid bits and restores the target to its default.
module great_circle_bearing_top
  import gcb_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // observer_latitude[23:0], observer_longitude[48:24]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // bearing[24:0]
  output logic        m_tuser,  // undefined_flag
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [24:0] cfg_data
);

  localparam vec_t TOL = vec_t'((64'sd1 <<< (32 - CORDIC_ITERATIONS)) + 64'sd64);

  logic ce;
  logic signed [23:0] tlat;
  logic signed [24:0] tlon;

  logic va;
  ang_t lane_ang [LANES];
  logic sc_valid;
  trig_t sn [LANES];
  trig_t cs [LANES];

  logic v1, v2, v3, v4;
  trig_t x1, p1, p2, cd1;
  trig_t x2, p1b, p3;
  trig_t x3;
  logic signed [32:0] y3;
  vec_t x4, y4;
  logic u4;

  logic at_valid;
  ang_t at_angle;
  logic at_flag;

  logic vf;
  ang_t zf;
  logic uf;
  logic [26:0] rnd;

  logic [24:0] bearing;

  assign ce = !m_tvalid || m_tready;
  assign s_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      tlat <= TLAT_RESET;
      tlon <= TLON_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TLAT: tlat <= cfg_data[23:0];
        REG_TLON: tlon <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ce) begin
      va <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      lane_ang[LANE_LAT] <= ang_t'($signed(s_tdata[23:0])) <<< FRAC_BITS;
      lane_ang[LANE_TLAT] <= ang_t'(tlat) <<< FRAC_BITS;
      lane_ang[LANE_DLON] <= (ang_t'(tlon) - ang_t'($signed(s_tdata[48:24]))) <<< FRAC_BITS;
    end
  end

  gcb_sincos #(
    .ITERS(CORDIC_ITERATIONS)
  ) u_sincos (
    .clk(clk),
    .rst(rst),
    .ce(ce),
    .in_valid(va),
    .ang(lane_ang),
    .out_valid(sc_valid),
    .sn(sn),
    .cs(cs)
  );

  logic signed [63:0] m_x, m_p1, m_p2, m_p3;
  assign m_x = 64'(cs[LANE_TLAT]) * 64'(sn[LANE_DLON]);
  assign m_p1 = 64'(cs[LANE_LAT]) * 64'(sn[LANE_TLAT]);
  assign m_p2 = 64'(sn[LANE_LAT]) * 64'(cs[LANE_TLAT]);
  assign m_p3 = 64'(p2) * 64'(cd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (ce) begin
      v1 <= sc_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x1 <= trig_t'(m_x >>> 30);
      p1 <= trig_t'(m_p1 >>> 30);
      p2 <= trig_t'(m_p2 >>> 30);
      cd1 <= cs[LANE_DLON];
      x2 <= x1;
      p1b <= p1;
      p3 <= trig_t'(m_p3 >>> 30);
      x3 <= x2;
      y3 <= 33'(p1b) - 33'(p3);
      x4 <= vec_t'(x3);
      y4 <= vec_t'(y3);
      u4 <= (vec_t'(x3) <= TOL) && (vec_t'(x3) >= -TOL) &&
            (vec_t'(y3) <= TOL) && (vec_t'(y3) >= -TOL);
    end
  end

  gcb_atan2 #(
    .ITERS(CORDIC_ITERATIONS)
  ) u_atan2 (
    .clk(clk),
    .rst(rst),
    .ce(ce),
    .in_valid(v4),
    .east(x4),
    .north(y4),
    .in_flag(u4),
    .out_valid(at_valid),
    .angle(at_angle),
    .out_flag(at_flag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (ce) begin
      vf <= at_valid;
      m_tvalid <= vf;
    end
  end

  assign rnd = 27'((zf + (ang_t'(1) <<< 15)) >>> 16);

  always_ff @(posedge clk) begin
    if (ce) begin
      uf <= at_flag;
      if (at_angle < 0) begin
        zf <= at_angle + TURN;
      end else if (at_angle >= TURN) begin
        zf <= at_angle - TURN;
      end else begin
        zf <= at_angle;
      end
      m_tuser <= uf;
      if (uf) begin
        bearing <= '0;
      end else if (rnd >= 27'(FULL_TURN_OUT)) begin
        bearing <= 25'(rnd - 27'(FULL_TURN_OUT));
      end else begin
        bearing <= rnd[24:0];
      end
    end
  end

  assign m_tdata = {7'b0, bearing};

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> bearing == '0)
    else $error("undefined direction with nonzero bearing");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> bearing < FULL_TURN_OUT)
    else $error("bearing out of range");

  assert property (@(posedge clk)
    rst |=> !m_tvalid && !vf && !v4)
    else $error("pipeline valid not cleared by reset");

  assert property (@(posedge clk) disable iff (rst)
    !ce |=> $stable(bearing) && $stable(v4))
    else $error("pipeline moved during a stall");

endmodule

// File: dv/tb_great_circle_bearing_top.sv
`timescale 1ns / 1ps

module tb_great_circle_bearing_top;
  import gcb_pkg::*;

  localparam longint DEG = 64'sd1 << 32;
  localparam longint ROT = 360 * DEG;
  localparam longint HALF_ROT = 180 * DEG;
  localparam longint QUARTER_ROT = 90 * DEG;
  localparam int LAT_MAX = 5898240;
  localparam int LON_MAX = 11796480;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [24:0] bearing;
    logic        undefined_flag;
  } heading_t;

  class bearing_scoreboard;
    longint target_lat;
    longint target_lon;
    heading_t pending[$];
    int errors;

    function new();
      target_lat = longint'(TLAT_RESET);
      target_lon = longint'(TLON_RESET);
      errors = 0;
    endfunction

    // atan(2^-i) in degrees, 32 fraction bits.
    function longint atan_step_deg(int i);
      longint s;
      longint unsigned hi;
      longint unsigned lo;
      int n;
      int e;
      if (i == 0) return 45 * DEG;
      s = 0;
      for (n = 0; i * (2 * n + 1) <= 60; n++) begin
        e = i * (2 * n + 1);
        if (n % 2 == 1) s -= longint'((64'd1 << (60 - e)) / (2 * n + 1));
        else s += longint'((64'd1 << (60 - e)) / (2 * n + 1));
      end
      hi = longint'(s) >> 30;
      lo = s & ((64'd1 << 30) - 1);
      return longint'(((hi * 64'd15380218700) >> 26) + ((lo * 64'd15380218700) >> 56));
    endfunction

    function void rotate(input longint ang, output longint sn, output longint cs);
      longint r;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      bit flip;
      r = ang % ROT;
      flip = 0;
      if (r < 0) r += ROT;
      if (r >= HALF_ROT) r -= ROT;
      if (r > QUARTER_ROT) begin
        r = HALF_ROT - r;
        flip = 1;
      end else if (r < -QUARTER_ROT) begin
        r = -HALF_ROT - r;
        flip = 1;
      end
      x = longint'(KINV);
      y = 0;
      z = r;
      for (int i = 0; i < CORDIC_ITERS_DEF; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_step_deg(i);
        end else begin
          x += dx; y -= dy; z += atan_step_deg(i);
        end
      end
      sn = y;
      cs = flip ? -x : x;
    endfunction

    function longint heading_angle(longint east, longint north);
      longint u;
      longint v;
      longint z;
      longint du;
      longint dv;
      u = north;
      v = east;
      z = 0;
      if (u < 0) begin
        u = -u; v = -v; z = HALF_ROT;
      end
      for (int i = 0; i < CORDIC_ITERS_DEF; i++) begin
        du = v >>> i;
        dv = u >>> i;
        if (v >= 0) begin
          u += du; v -= dv; z += atan_step_deg(i);
        end else begin
          u -= du; v += dv; z -= atan_step_deg(i);
        end
      end
      if (z < 0) z += ROT;
      if (z >= ROT) z -= ROT;
      return z;
    endfunction

    function heading_t predict_heading(logic signed [23:0] lat, logic signed [24:0] lon);
      longint sl, cl, st, ct, sd, cd, x, y, tol, dl;
      longint unsigned b;
      heading_t h;
      dl = (target_lon <<< 16) - (longint'(lon) <<< 16);
      rotate(longint'(lat) <<< 16, sl, cl);
      rotate(target_lat <<< 16, st, ct);
      rotate(dl, sd, cd);
      x = (ct * sd) >>> 30;
      y = ((cl * st) >>> 30) - ((((sl * ct) >>> 30) * cd) >>> 30);
      tol = (64'sd1 << (32 - CORDIC_ITERS_DEF)) + 64;
      if (x <= tol && x >= -tol && y <= tol && y >= -tol) begin
        h.bearing = '0;
        h.undefined_flag = 1'b1;
        return h;
      end
      b = (longint'(heading_angle(x, y)) + (64'd1 << 15)) >> 16;
      if (b >= 64'(FULL_TURN_OUT)) b -= 64'(FULL_TURN_OUT);
      h.bearing = b[24:0];
      h.undefined_flag = 1'b0;
      return h;
    endfunction

    function void note_position(logic [55:0] data);
      pending.push_back(predict_heading(data[23:0], data[48:24]));
    endfunction

    function void check_heading(logic [24:0] bearing, logic undefined_flag);
      heading_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item, actual bearing %0d flag %0b", $time, bearing,
                 undefined_flag);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want.bearing !== bearing) begin
        $display("%0t: bearing mismatch, expected %0d actual %0d", $time, want.bearing,
                 bearing);
        errors++;
      end
      if (want.undefined_flag !== undefined_flag) begin
        $display("%0t: undefined flag mismatch, expected %0b actual %0b", $time,
                 want.undefined_flag, undefined_flag);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [55:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [31:0] m_tdata;
  logic m_tuser;
  logic cfg_we;
  logic cfg_addr;
  logic [24:0] cfg_data;

  bearing_scoreboard sb = new();
  bit gaps_on;
  bit rx_hold_done;
  int rx_count;
  int quiet_cycles;

  great_circle_bearing_top i_dut (.*);

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_position(s_tdata);
    if (!rst && m_tvalid && m_tready) begin
      sb.check_heading(m_tdata[24:0], m_tuser);
      rx_count++;
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver with random stalls and one long hold-off to back up the pipeline.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = gaps_on ? $urandom_range(0, 5) : 0;
      if (!rx_hold_done && rx_count >= 200) begin
        stall = 300;
        rx_hold_done = 1;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic send_position(int lat, int lon);
    int gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, 25'(lon), 24'(lat)};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_target(int lat, int lon);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_TLAT;
    cfg_data <= 25'(lat);
    @(posedge clk);
    cfg_addr <= REG_TLON;
    cfg_data <= 25'(lon);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.target_lat = longint'(lat);
    sb.target_lon = longint'(lon);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_random(int count);
    int kind;
    int tl;
    int tn;
    tl = int'(sb.target_lat);
    tn = int'(sb.target_lon);
    repeat (count) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          send_position(int'($signed(24'($urandom))), int'($signed(25'($urandom))));
        end
        1: begin
          send_position(tl + $urandom_range(0, 8) - 4, tn + $urandom_range(0, 8) - 4);
        end
        2: begin
          send_position(-tl + $urandom_range(0, 8) - 4,
                        (tn > 0 ? tn - LON_MAX : tn + LON_MAX) + $urandom_range(0, 8) - 4);
        end
        3: begin
          send_position(($urandom_range(0, 1) ? LAT_MAX : -LAT_MAX) - $urandom_range(0, 3),
                        $urandom_range(0, 2 * LON_MAX) - LON_MAX);
        end
        default: begin
          send_position($urandom_range(0, 2 * LAT_MAX) - LAT_MAX,
                        $urandom_range(0, 2 * LON_MAX) - LON_MAX);
        end
      endcase
    end
  endtask

  initial begin
    int tl;
    int tn;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = REG_TLAT;
    cfg_data = '0;
    gaps_on = 1;
    rx_hold_done = 0;
    rx_count = 0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tl = int'(TLAT_RESET);
    tn = int'(TLON_RESET);
    send_position(0, 0);
    send_position(LAT_MAX, 0);
    send_position(-LAT_MAX, 0);
    send_position(0, LON_MAX);
    send_position(0, -LON_MAX);
    send_position(LAT_MAX, LON_MAX);
    send_position(-LAT_MAX, -LON_MAX);
    send_position(tl, tn);
    send_position(-tl, tn - LON_MAX);
    send_position(tl, tn + 2 * LON_MAX);
    send_position(tl + 1, tn);
    send_position(tl, tn - 1);
    send_position(-8388608, -16777216);
    send_position(8388607, 16777215);
    send_position(tl, -LON_MAX);
    send_position(-tl, tn);
    send_random(150);
    drain();

    write_target(LAT_MAX, -LON_MAX);
    gaps_on = 0;
    send_position(LAT_MAX, 0);
    send_random(150);
    drain();

    write_target(-LAT_MAX, LON_MAX);
    gaps_on = 1;
    send_random(150);
    drain();

    write_target(0, 0);
    send_position(0, 0);
    send_position(0, LON_MAX);
    send_random(150);
    drain();

    write_target($urandom_range(0, 2 * LAT_MAX) - LAT_MAX,
                 $urandom_range(0, 2 * LON_MAX) - LON_MAX);
    send_random(150);
    drain();

    write_target(int'(TLAT_RESET), int'(TLON_RESET));
    send_random(120);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: great_circle_bearing_top.f
sv/gcb_pkg.sv
sv/gcb_sincos.sv
sv/gcb_atan2.sv
sv/great_circle_bearing_top.sv
dv/tb_great_circle_bearing_top.sv
